// ===== design/wsme_pkg.sv =====
// Shared types and constants for the stack machine executor.
// Depends on nothing; imported by every module of the block.
package wsme_pkg;

    localparam int OPSTK_DEPTH  = 64;
    localparam int FRAME_DEPTH  = 16;
    localparam int MEMORY_BYTES = 65536;

    localparam int SA  = $clog2(OPSTK_DEPTH);
    localparam int SPW = $clog2(OPSTK_DEPTH + 1);
    localparam int FA  = $clog2(FRAME_DEPTH);
    localparam int FCW = $clog2(FRAME_DEPTH + 1);
    localparam int MA  = $clog2(MEMORY_BYTES);
    localparam int MLW = $clog2(MEMORY_BYTES + 1);

    localparam int IN_DATA_W  = 184;
    localparam int OUT_DATA_W = 88;

    typedef enum logic [4:0] {
        M_START = 5'd0,  M_I64C  = 5'd1,  M_I32C = 5'd2,  M_LGET  = 5'd3,
        M_LSET  = 5'd4,  M_LTEE  = 5'd5,  M_LOAD = 5'd6,  M_STORE = 5'd7,
        M_MSIZE = 5'd8,  M_NE    = 5'd9,  M_EQ   = 5'd10, M_LTU   = 5'd11,
        M_AND   = 5'd12, M_ADD   = 5'd13, M_EQZ  = 5'd14, M_WRAP  = 5'd15,
        M_BLOCK = 5'd16, M_LOOP  = 5'd17, M_IF   = 5'd18, M_ELSE  = 5'd19,
        M_BRIF  = 5'd20, M_BR    = 5'd21, M_END  = 5'd22, M_DROP  = 5'd23
    } t_mode;

    typedef enum logic [1:0] {
        K_BLOCK = 2'd0, K_LOOP = 2'd1, K_IF = 2'd2
    } t_kind;

    typedef struct packed {
        t_mode       mode;
        logic [1:0]  access_width;
        logic [63:0] immediate;
        logic [31:0] index;
        logic [31:0] offset;
        logic [15:0] pc_after;
        logic [15:0] end_pc;
        logic [15:0] else_pc;
    } t_instr;

    typedef struct packed {
        logic [15:0] next_pc;
        logic        jumped;
        logic        finished;
        logic [63:0] return_value;
        logic        fault;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic mrd;
        logic mcap;
        logic lwb;
        logic done;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic           mem_go;
        logic           is_load;
        logic           last;
        logic           out_free;
        logic [SPW-1:0] sp;
        logic [FCW-1:0] fc;
    } t_st;

endpackage

// ===== design/wsme_ctrl.sv =====
// Sequencer for the executor: one instruction at a time through read,
// execute, byte-serial memory access and result hand-off. Uses wsme_pkg.
module wsme_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  wsme_pkg::t_st i_st,
    output wsme_pkg::t_cmd o_cmd
);
    import wsme_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_MRD  = 6'b000100,
        S_MCAP = 6'b001000,
        S_LWB  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = i_st.mem_go ? S_MRD : S_DONE;
            end
            S_MRD: begin
                o_cmd.mrd = 1'b1;
                if (i_st.is_load) n_state = S_MCAP;
                else if (i_st.last) n_state = S_DONE;
            end
            S_MCAP: begin
                o_cmd.mcap = 1'b1;
                n_state = i_st.last ? S_LWB : S_MRD;
            end
            S_LWB: begin
                o_cmd.lwb = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

endmodule

// ===== design/wsme_dp.sv =====
// Datapath: operand stack, locals, control frames, linear memory, config
// and the result register. Driven by wsme_ctrl commands; uses wsme_pkg.
module wsme_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wsme_pkg::t_cmd  i_cmd,
    output wsme_pkg::t_st   o_st,
    input  wsme_pkg::t_instr i_in,
    input  logic            i_cfg_valid,
    input  logic            i_cfg_index,
    input  logic [16:0]     i_cfg_data,
    output wsme_pkg::t_res  o_res,
    output logic            o_res_valid,
    input  logic            i_res_ready
);
    import wsme_pkg::*;

    // storage
    logic [63:0]    stk_mem [OPSTK_DEPTH];
    logic [63:0]    loc_mem [OPSTK_DEPTH];
    logic [1:0]     frm_kind [FRAME_DEPTH];
    logic [15:0]    frm_start [FRAME_DEPTH];
    logic [15:0]    frm_end [FRAME_DEPTH];
    logic [SPW-1:0] frm_depth [FRAME_DEPTH];
    logic [7:0]     lin_mem [MEMORY_BYTES];

    logic [OPSTK_DEPTH-1:0] r_lval;
    logic [SPW-1:0] r_sp, n_sp;
    logic [FCW-1:0] r_fc, n_fc;
    logic           r_fault, n_fault;
    logic [6:0]     r_lcnt;
    logic [16:0]    r_mbytes;
    t_instr         r_in;
    logic [63:0]    r_top, r_sec, r_lrd;
    logic           r_lv;
    logic [1:0]     r_fk;
    logic [15:0]    r_fs, r_fe;
    logic [SPW-1:0] r_fd;
    logic [MA-1:0]  r_maddr;
    logic [2:0]     r_mcnt;
    logic [63:0]    r_mval;
    logic [7:0]     r_mrd;
    t_res           r_res, n_res;
    t_res           r_out;
    logic           r_ovalid;

    logic           ok, swe, lwe, fpush, clr_loc, mem_go;
    logic [SA-1:0]  swa;
    logic [63:0]    swd;
    logic [1:0]     fp_kind;
    logic [15:0]    fp_start;
    logic [SPW-1:0] fp_depth;
    logic [63:0]    loc_val, base;
    logic [31:0]    lim32, llim32;
    logic [MLW-1:0] lim;
    logic [MLW+1:0] mem_end;
    logic [3:0]     wbytes;
    logic           rng_ok, loc_ok, cond;
    logic [SPW-1:0] after;
    logic [FA-1:0]  frd_addr;
    logic [MA-1:0]  lin_addr;

    assign lim32   = ({15'd0, r_mbytes} > 32'(MEMORY_BYTES)) ? 32'(MEMORY_BYTES)
                                                             : {15'd0, r_mbytes};
    assign lim     = lim32[MLW-1:0];
    assign llim32  = ({25'd0, r_lcnt} > 32'(OPSTK_DEPTH)) ? 32'(OPSTK_DEPTH)
                                                          : {25'd0, r_lcnt};
    assign loc_ok  = r_in.index < llim32;
    assign loc_val = r_lv ? r_lrd : 64'd0;
    assign wbytes  = 4'd1 << r_in.access_width;
    assign base    = (r_in.mode == M_LOAD) ? r_top : r_sec;
    assign mem_end = (MLW+2)'(base[MLW-1:0]) + (MLW+2)'(r_in.offset[MLW-1:0])
                   + (MLW+2)'(wbytes);
    assign rng_ok  = (base[63:MLW] == '0) && (r_in.offset[31:MLW] == '0)
                   && (mem_end <= (MLW+2)'(lim));
    assign cond    = r_top[31:0] != 32'd0;
    assign after   = (r_in.mode == M_BRIF) ? r_sp - SPW'(1) : r_sp;

    // frame read address: top frame for else, branch target otherwise
    assign frd_addr = (i_in.mode == M_ELSE) ? FA'(r_fc - FCW'(1))
                    : FA'(r_fc - FCW'(1) - i_in.index[FCW-1:0]);

    // execute one instruction
    always_comb begin
        ok       = 1'b1;
        swe      = 1'b0;
        swa      = SA'(r_sp);
        swd      = 64'd0;
        lwe      = 1'b0;
        fpush    = 1'b0;
        fp_kind  = K_BLOCK;
        fp_start = r_in.pc_after;
        fp_depth = r_sp;
        clr_loc  = 1'b0;
        mem_go   = 1'b0;
        n_sp     = r_sp;
        n_fc     = r_fc;
        n_fault  = r_fault;
        n_res.next_pc      = r_in.pc_after;
        n_res.finished     = 1'b0;
        n_res.return_value = 64'd0;
        if (r_in.mode == M_START) begin
            n_sp = '0;
            n_fc = '0;
            n_fault = 1'b0;
            clr_loc = 1'b1;
        end else if (!r_fault) begin
            case (r_in.mode)
                M_I64C, M_I32C, M_LGET, M_MSIZE: begin
                    if (r_sp == SPW'(OPSTK_DEPTH)) ok = 1'b0;
                    else if (r_in.mode == M_LGET && !loc_ok) ok = 1'b0;
                    else if (r_in.mode == M_MSIZE && r_in.index != 32'd0) ok = 1'b0;
                    swe  = 1'b1;
                    n_sp = r_sp + SPW'(1);
                    case (r_in.mode)
                        M_I64C:  swd = r_in.immediate;
                        M_I32C:  swd = {32'd0, r_in.immediate[31:0]};
                        M_LGET:  swd = loc_val;
                        default: swd = 64'(lim32 >> 16);
                    endcase
                end
                M_LSET, M_LTEE: begin
                    if (!loc_ok || r_sp == '0) ok = 1'b0;
                    lwe = 1'b1;
                    if (r_in.mode == M_LSET) n_sp = r_sp - SPW'(1);
                end
                M_LOAD, M_STORE: begin
                    if (r_in.mode == M_LOAD && r_sp == '0) ok = 1'b0;
                    else if (r_in.mode == M_STORE && r_sp < SPW'(2)) ok = 1'b0;
                    else if (!rng_ok) ok = 1'b0;
                    mem_go = 1'b1;
                    if (r_in.mode == M_STORE) n_sp = r_sp - SPW'(2);
                end
                M_NE, M_EQ, M_LTU, M_AND, M_ADD: begin
                    if (r_sp < SPW'(2)) ok = 1'b0;
                    swe  = 1'b1;
                    swa  = SA'(r_sp - SPW'(2));
                    n_sp = r_sp - SPW'(1);
                    case (r_in.mode)
                        M_NE:    swd = {63'd0, r_sec != r_top};
                        M_EQ:    swd = {63'd0, r_sec == r_top};
                        M_LTU:   swd = {63'd0, r_sec < r_top};
                        M_AND:   swd = r_sec & r_top;
                        default: swd = r_sec + r_top;
                    endcase
                end
                M_EQZ, M_WRAP: begin
                    if (r_sp == '0) ok = 1'b0;
                    swe = 1'b1;
                    swa = SA'(r_sp - SPW'(1));
                    swd = (r_in.mode == M_EQZ) ? {63'd0, !cond} : {32'd0, r_top[31:0]};
                end
                M_BLOCK, M_LOOP: begin
                    if (r_fc == FCW'(FRAME_DEPTH)) ok = 1'b0;
                    fpush   = 1'b1;
                    fp_kind = (r_in.mode == M_LOOP) ? K_LOOP : K_BLOCK;
                    n_fc    = r_fc + FCW'(1);
                end
                M_IF: begin
                    if (r_sp == '0 || r_fc == FCW'(FRAME_DEPTH)) ok = 1'b0;
                    n_sp     = r_sp - SPW'(1);
                    fpush    = 1'b1;
                    fp_kind  = K_IF;
                    fp_depth = r_sp - SPW'(1);
                    n_fc     = r_fc + FCW'(1);
                    if (cond) fp_start = r_in.pc_after;
                    else if (r_in.else_pc != 16'd0) fp_start = r_in.else_pc;
                    else fp_start = r_in.end_pc;
                    n_res.next_pc = fp_start;
                end
                M_ELSE: begin
                    if (r_fc == '0 || r_fk != K_IF) ok = 1'b0;
                    n_res.next_pc = r_fe;
                end
                M_BRIF, M_BR: begin
                    if (r_in.mode == M_BRIF && r_sp == '0) ok = 1'b0;
                    else if (r_in.mode == M_BRIF && !cond) n_sp = after;
                    else if (r_in.index >= 32'(r_fc)) ok = 1'b0;
                    else begin
                        n_sp = (r_fd <= after) ? r_fd : after;
                        n_fc = r_fc - r_in.index[FCW-1:0];
                        n_res.next_pc = (r_fk == K_LOOP) ? r_fs : r_fe;
                    end
                end
                M_END: begin
                    if (r_fc == '0) begin
                        n_res.finished = 1'b1;
                        n_res.return_value = (r_sp != '0) ? r_top : 64'd0;
                    end else begin
                        n_fc = r_fc - FCW'(1);
                    end
                end
                M_DROP: begin
                    if (r_sp == '0) ok = 1'b0;
                    n_sp = r_sp - SPW'(1);
                end
                default: ok = 1'b0;
            endcase
            // a failing check leaves all state but the fault flag
            if (!ok) begin
                n_fault = 1'b1;
                swe = 1'b0; lwe = 1'b0; fpush = 1'b0; mem_go = 1'b0;
                n_sp = r_sp;
                n_fc = r_fc;
                n_res.next_pc = r_in.pc_after;
                n_res.finished = 1'b0;
                n_res.return_value = 64'd0;
            end
        end
        n_res.fault  = n_fault;
        n_res.jumped = n_res.next_pc != r_in.pc_after;
    end

    assign lin_addr = r_maddr + MA'(r_mcnt);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp     <= '0;
            r_fc     <= '0;
            r_fault  <= 1'b0;
            r_lval   <= '0;
            r_lcnt   <= 7'd0;
            r_mbytes <= 17'd65536;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index) r_mbytes <= i_cfg_data;
                else r_lcnt <= i_cfg_data[6:0];
            end
            if (i_cmd.exec) begin
                r_sp    <= n_sp;
                r_fc    <= n_fc;
                r_fault <= n_fault;
                if (clr_loc) r_lval <= '0;
                else if (lwe) r_lval[r_in.index[SA-1:0]] <= 1'b1;
            end
            if (i_cmd.done) r_ovalid <= 1'b1;
            else if (i_res_ready) r_ovalid <= 1'b0;
        end
    end

    // payload registers and memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in  <= i_in;
            r_top <= stk_mem[SA'(r_sp - SPW'(1))];
            r_sec <= stk_mem[SA'(r_sp - SPW'(2))];
            r_lrd <= loc_mem[i_in.index[SA-1:0]];
            r_lv  <= r_lval[i_in.index[SA-1:0]];
            r_fk  <= frm_kind[frd_addr];
            r_fs  <= frm_start[frd_addr];
            r_fe  <= frm_end[frd_addr];
            r_fd  <= frm_depth[frd_addr];
        end
        if (i_cmd.exec && swe) stk_mem[swa] <= swd;
        else if (i_cmd.lwb) stk_mem[SA'(r_sp - SPW'(1))] <= r_mval;
        if (i_cmd.exec && lwe) loc_mem[r_in.index[SA-1:0]] <= r_top;
        if (i_cmd.exec && fpush) begin
            frm_kind[r_fc[FA-1:0]]  <= fp_kind;
            frm_start[r_fc[FA-1:0]] <= fp_start;
            frm_end[r_fc[FA-1:0]]   <= r_in.end_pc;
            frm_depth[r_fc[FA-1:0]] <= fp_depth;
        end
        if (i_cmd.exec) begin
            r_res   <= n_res;
            r_maddr <= MA'(mem_end - (MLW+2)'(wbytes));
            r_mcnt  <= 3'd0;
            r_mval  <= (r_in.mode == M_STORE) ? r_top : 64'd0;
        end
        // one byte per step, little-endian
        if (i_cmd.mrd && r_in.mode == M_STORE) begin
            lin_mem[lin_addr] <= r_mval[{r_mcnt, 3'b000} +: 8];
            r_mcnt <= r_mcnt + 3'd1;
        end
        if (i_cmd.mrd) r_mrd <= lin_mem[lin_addr];
        if (i_cmd.mcap) begin
            r_mval[{r_mcnt, 3'b000} +: 8] <= r_mrd;
            r_mcnt <= r_mcnt + 3'd1;
        end
        if (i_cmd.done) r_out <= r_res;
    end

    assign o_st.mem_go   = mem_go;
    assign o_st.is_load  = r_in.mode == M_LOAD;
    assign o_st.last     = r_mcnt == 3'(wbytes - 4'd1);
    assign o_st.out_free = !r_ovalid || i_res_ready;
    assign o_st.sp       = r_sp;
    assign o_st.fc       = r_fc;
    assign o_res         = r_out;
    assign o_res_valid   = r_ovalid;

endmodule

// ===== design/wasm_stack_machine_executor.sv =====
// Stack machine executor: one decoded instruction per input word.
// Each instruction passes accept, execute and done before the next is taken;
// loads add a read and a capture state per byte plus a write-back, stores
// one memory state per byte, set by the byte-wide linear memory port.
// Reset (synchronous, active low) clears stack pointer, frame count, fault
// flag and local valid bits at once; no clearing pass.
module wasm_stack_machine_executor (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // access_width, immediate, index, offset, pc_after, end_pc, else_pc
    input  logic [wsme_pkg::IN_DATA_W-1:0] i_s_tdata,
    // mode
    input  logic [4:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // next_pc, jumped, return_value, fault
    output logic [wsme_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic         o_m_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [16:0]  i_cfg_data
);
    import wsme_pkg::*;

    t_cmd   cmd;
    t_st    st;
    t_instr in_w;
    t_res   res;

    // unpack input word
    assign in_w.mode         = t_mode'(i_s_tuser);
    assign in_w.access_width = i_s_tdata[1:0];
    assign in_w.immediate    = i_s_tdata[65:2];
    assign in_w.index        = i_s_tdata[97:66];
    assign in_w.offset       = i_s_tdata[129:98];
    assign in_w.pc_after     = i_s_tdata[145:130];
    assign in_w.end_pc       = i_s_tdata[161:146];
    assign in_w.else_pc      = i_s_tdata[177:162];

    assign o_cfg_ready = 1'b1;

    wsme_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    wsme_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_in        (in_w),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res       (res),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready)
    );

    // pack result word
    assign o_m_tdata = {6'd0, res.fault, res.return_value, res.jumped, res.next_pc};
    assign o_m_tlast = res.finished;

    // one instruction in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second word accepted while busy");

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st.sp <= SPW'(OPSTK_DEPTH))
        else $error("stack pointer beyond depth");

    a_fc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st.fc <= FCW'(FRAME_DEPTH))
        else $error("frame count beyond depth");

    a_fin_nofault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> !o_m_tdata[81])
        else $error("finished together with fault");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the stack machine executor.
// Depends on wsme_pkg and wasm_stack_machine_executor from the design folder.
`timescale 1ns / 1ps

module tb;
    import wsme_pkg::*;

    localparam logic [4:0] MODE_BAD = 5'd24;
    localparam logic CFG_LOCALS = 1'b0;
    localparam logic CFG_MEMORY = 1'b1;
    localparam int   SETTLE     = 40;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [183:0] s_tdata = '0;
    logic [4:0]   s_tuser = '0;
    logic         m_tready = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_index = 1'b0;
    logic [16:0]  cfg_data = '0;
    logic         o_s_tready, o_m_tvalid, o_m_tlast, o_cfg_ready;
    logic [87:0]  o_m_tdata;

    wasm_stack_machine_executor i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tlast(o_m_tlast),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // instructions waiting to be sent and results still owed by the block
    t_instr instr_q[$];
    t_res   result_q[$];
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     hold_tag = 0;
    int     hold_seen = 0;
    int     hold_left = 0;
    int     mismatches = 0;

    // shadow machine state
    logic [63:0] opstk[64];
    logic [63:0] locals[64];
    t_kind       fr_kind[16];
    logic [15:0] fr_start[16];
    logic [15:0] fr_end[16];
    int          fr_depth[16];
    int          sp_m, fc_m;
    logic        flt;
    logic [7:0]  lmem[65536];
    bit          lmem_set[65536];
    logic [6:0]  loc_cnt;
    logic [16:0] mem_size;
    logic [15:0] gen_pc;

    function automatic logic [63:0] mem_lim();
        return mem_size > 17'd65536 ? 64'd65536 : 64'(mem_size);
    endfunction

    function automatic logic [63:0] loc_lim();
        return loc_cnt > 7'd64 ? 64'd64 : 64'(loc_cnt);
    endfunction

    // true when the access lies in range but touches a byte never stored
    function automatic bit load_unsafe(t_instr it);
        logic [63:0] base, w, lim, a;
        if (flt || sp_m < 1) return 0;
        base = opstk[sp_m-1];
        w = 64'd1 << it.access_width;
        lim = mem_lim();
        if (base > lim || 64'(it.offset) > lim - base || w > lim - base - 64'(it.offset))
            return 0;
        for (int k = 0; k < int'(w); k++) begin
            a = base + 64'(it.offset) + 64'(k);
            if (!lmem_set[a[15:0]]) return 1;
        end
        return 0;
    endfunction

    // execute one instruction on the shadow state and give its result
    function automatic t_res exec_predict(t_instr it);
        t_res r;
        bit ok, cond;
        logic [63:0] base, val, w, lim, addr, v, l, rr;
        logic [15:0] nxt, st;
        int f, after;
        ok = 1;
        nxt = it.pc_after;
        r = '0;
        if (it.mode == M_START) begin
            sp_m = 0;
            fc_m = 0;
            flt = 0;
            foreach (locals[i]) locals[i] = '0;
        end else if (!flt) begin
            case (it.mode)
                M_I64C, M_I32C, M_LGET, M_MSIZE: begin
                    if (sp_m >= 64) ok = 0;
                    else if (it.mode == M_LGET && 64'(it.index) >= loc_lim()) ok = 0;
                    else if (it.mode == M_MSIZE && it.index != 0) ok = 0;
                    else begin
                        case (it.mode)
                            M_I64C: opstk[sp_m] = it.immediate;
                            M_I32C: opstk[sp_m] = {32'd0, it.immediate[31:0]};
                            M_LGET: opstk[sp_m] = locals[it.index[5:0]];
                            default: opstk[sp_m] = mem_lim() >> 16;
                        endcase
                        sp_m++;
                    end
                end
                M_LSET, M_LTEE: begin
                    if (64'(it.index) >= loc_lim() || sp_m == 0) ok = 0;
                    else begin
                        locals[it.index[5:0]] = opstk[sp_m-1];
                        if (it.mode == M_LSET) sp_m--;
                    end
                end
                M_LOAD, M_STORE: begin
                    w = 64'd1 << it.access_width;
                    lim = mem_lim();
                    if (sp_m < (it.mode == M_LOAD ? 1 : 2)) ok = 0;
                    else begin
                        base = opstk[sp_m - (it.mode == M_LOAD ? 1 : 2)];
                        val = opstk[sp_m-1];
                        if (base > lim || 64'(it.offset) > lim - base
                            || w > lim - base - 64'(it.offset)) ok = 0;
                        else begin
                            addr = base + 64'(it.offset);
                            v = '0;
                            for (int k = 0; k < int'(w); k++) begin
                                if (it.mode == M_LOAD) begin
                                    v[8*k +: 8] = lmem[16'(addr + 64'(k))];
                                end else begin
                                    lmem[16'(addr + 64'(k))] = val[8*k +: 8];
                                    lmem_set[16'(addr + 64'(k))] = 1;
                                end
                            end
                            if (it.mode == M_LOAD) opstk[sp_m-1] = v;
                            else sp_m -= 2;
                        end
                    end
                end
                M_NE, M_EQ, M_LTU, M_AND, M_ADD: begin
                    if (sp_m < 2) ok = 0;
                    else begin
                        l = opstk[sp_m-2];
                        rr = opstk[sp_m-1];
                        case (it.mode)
                            M_NE:  v = 64'(l != rr);
                            M_EQ:  v = 64'(l == rr);
                            M_LTU: v = 64'(l < rr);
                            M_AND: v = l & rr;
                            default: v = l + rr;
                        endcase
                        opstk[sp_m-2] = v;
                        sp_m--;
                    end
                end
                M_EQZ, M_WRAP: begin
                    if (sp_m == 0) ok = 0;
                    else if (it.mode == M_EQZ) opstk[sp_m-1] = 64'(opstk[sp_m-1][31:0] == 0);
                    else opstk[sp_m-1] = {32'd0, opstk[sp_m-1][31:0]};
                end
                M_BLOCK, M_LOOP, M_IF: begin
                    if (fc_m >= 16 || (it.mode == M_IF && sp_m == 0)) ok = 0;
                    else begin
                        st = it.pc_after;
                        if (it.mode == M_IF) begin
                            cond = opstk[sp_m-1][31:0] != 0;
                            sp_m--;
                            if (!cond) st = it.else_pc != 0 ? it.else_pc : it.end_pc;
                            nxt = st;
                        end
                        fr_kind[fc_m] = it.mode == M_BLOCK ? K_BLOCK :
                                        it.mode == M_LOOP ? K_LOOP : K_IF;
                        fr_start[fc_m] = st;
                        fr_end[fc_m] = it.end_pc;
                        fr_depth[fc_m] = sp_m;
                        fc_m++;
                    end
                end
                M_ELSE: begin
                    if (fc_m == 0 || fr_kind[fc_m-1] != K_IF) ok = 0;
                    else nxt = fr_end[fc_m-1];
                end
                M_BRIF, M_BR: begin
                    after = sp_m;
                    cond = 1;
                    if (it.mode == M_BRIF) begin
                        if (sp_m == 0) ok = 0;
                        else begin
                            after = sp_m - 1;
                            if (opstk[sp_m-1][31:0] == 0) begin
                                sp_m = after;
                                cond = 0;
                            end
                        end
                    end
                    if (ok && cond) begin
                        if (64'(it.index) >= 64'(fc_m)) ok = 0;
                        else begin
                            f = fc_m - 1 - int'(it.index);
                            sp_m = fr_depth[f] <= after ? fr_depth[f] : after;
                            fc_m = f + 1;
                            nxt = fr_kind[f] == K_LOOP ? fr_start[f] : fr_end[f];
                        end
                    end
                end
                M_END: begin
                    if (fc_m == 0) begin
                        r.finished = 1;
                        r.return_value = sp_m != 0 ? opstk[sp_m-1] : '0;
                    end else fc_m--;
                end
                M_DROP: begin
                    if (sp_m == 0) ok = 0;
                    else sp_m--;
                end
                default: ok = 0;
            endcase
            if (!ok) begin
                flt = 1;
                nxt = it.pc_after;
                r.finished = 0;
                r.return_value = '0;
            end
        end
        r.next_pc = nxt;
        r.jumped = nxt != it.pc_after;
        r.fault = flt;
        return r;
    endfunction

    // queue one instruction; a load of never-stored bytes becomes a constant
    task automatic issue(t_instr it);
        if (it.mode == M_LOAD && load_unsafe(it)) it.mode = M_I64C;
        gen_pc += 16'(1 + $urandom_range(0, 7));
        if (it.pc_after == 0) it.pc_after = gen_pc;
        result_q.push_back(exec_predict(it));
        instr_q.push_back(it);
    endtask

    task automatic op(t_mode m, logic [63:0] imm = 0, logic [31:0] idx = 0,
                      logic [31:0] ofs = 0, logic [1:0] aw = 0,
                      logic [15:0] endp = 0, logic [15:0] elsep = 0);
        t_instr it;
        it = '{mode: m, access_width: aw, immediate: imm, index: idx, offset: ofs,
               pc_after: 16'd0, end_pc: endp, else_pc: elsep};
        issue(it);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_addr();
        logic [63:0] lim;
        lim = mem_lim();
        case ($urandom_range(0, 9))
            0: return rnd64();
            1: return lim > 8 ? lim - 64'($urandom_range(0, 8)) : lim;
            default: return 64'($urandom_range(0, lim > 72 ? 64 : 0));
        endcase
    endfunction

    // one random instruction or a short well-formed snippet
    task automatic random_step();
        t_instr it;
        logic [63:0] a;
        int sel;
        sel = $urandom_range(0, 99);
        if (flt && $urandom_range(0, 3) != 0) begin
            op(M_START);
        end else if (sel < 18) begin
            a = pick_addr();
            op(M_I64C, a);
            op(M_I64C, rnd64());
            op(M_STORE, 0, $urandom, $urandom_range(0, 3) == 0 ? $urandom
               : $urandom_range(0, 8), 2'($urandom));
            op(M_I64C, a);
            op(M_LOAD, 0, $urandom, $urandom_range(0, 8), 2'($urandom));
        end else if (sel < 28) begin
            op($urandom_range(0, 1) ? M_BLOCK : M_LOOP, 0, 0, 0, 0, 16'($urandom));
            op(M_I32C, 64'($urandom_range(0, 1)));
            op($urandom_range(0, 1) ? M_BRIF : M_BR, 0, $urandom_range(0, 2));
            op(M_END);
        end else if (sel < 36) begin
            op(M_I64C, 64'($urandom_range(0, 1)) << $urandom_range(0, 40));
            op(M_IF, 0, 0, 0, 0, 16'($urandom),
               $urandom_range(0, 1) ? 16'd0 : 16'($urandom));
            op(M_I64C, rnd64());
            if ($urandom_range(0, 1)) op(M_ELSE);
            op(M_END);
        end else if (sel < 40) begin
            op(M_END);
        end else begin
            it.mode = sel < 42 ? t_mode'(5'($urandom_range(24, 31))) :
                      t_mode'(5'($urandom_range(0, 23)));
            it.access_width = 2'($urandom);
            it.immediate = rnd64();
            it.index = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 66);
            if (it.mode == M_MSIZE && $urandom_range(0, 3) != 0) it.index = 0;
            it.offset = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 16);
            it.pc_after = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'd0;
            it.end_pc = 16'($urandom);
            it.else_pc = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
            if (it.mode == M_START && $urandom_range(0, 3) != 0) it.mode = M_I64C;
            issue(it);
        end
    endtask

    task automatic drain();
        while (!(instr_q.size() == 0 && !s_tvalid && result_q.size() == 0))
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [16:0] d);
        cfg_index <= idx;
        cfg_data <= d;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!(cfg_valid && o_cfg_ready));
        cfg_valid <= 1'b0;
        if (idx == CFG_LOCALS) loc_cnt = d[6:0];
        else mem_size = d;
    endtask

    task automatic run_phase(int n, int snd, int rcv, logic [6:0] lc, logic [16:0] mb);
        drain();
        write_reg(CFG_LOCALS, {10'd0, lc});
        write_reg(CFG_MEMORY, mb);
        send_idle_pct = snd;
        recv_idle_pct = rcv;
        op(M_START);
        for (int i = 0; i < n; i++) begin
            random_step();
            // long receiver hold-off, later a sender pause until drained
            if (i == n / 3 && n > 100) hold_tag++;
            if (i == 2 * n / 3 && n > 100) begin
                while (!(instr_q.size() == 0 && result_q.size() == 0))
                    @(posedge i_clk);
            end
        end
    endtask

    // sender: hold the word until taken, then offer the next
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || o_s_tready) begin
            if (instr_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                t_instr it;
                it = instr_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= it.mode;
                s_tdata <= {6'd0, it.else_pc, it.end_pc, it.pc_after, it.offset,
                            it.index, it.immediate, it.access_width};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus the counted hold-off
    always @(posedge i_clk) begin
        if (hold_seen != hold_tag) begin
            hold_seen <= hold_tag;
            hold_left <= 400;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= $urandom_range(0, 99) >= recv_idle_pct;
        end
    end

    // compare each result word against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && m_tready) begin
            t_res got, want;
            got.next_pc = o_m_tdata[15:0];
            got.jumped = o_m_tdata[16];
            got.return_value = o_m_tdata[80:17];
            got.fault = o_m_tdata[81];
            got.finished = o_m_tlast;
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", o_m_tdata);
            end else begin
                want = result_q.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %h %b %b %h %b got %h %b %b %h %b",
                                 want.next_pc, want.jumped, want.finished,
                                 want.return_value, want.fault, got.next_pc,
                                 got.jumped, got.finished, got.return_value, got.fault);
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        sp_m = 0;
        fc_m = 0;
        flt = 0;
        loc_cnt = '0;
        mem_size = 17'd65536;
        gen_pc = '0;
        foreach (locals[i]) locals[i] = '0;
        foreach (lmem[i]) begin
            lmem[i] = '0;
            lmem_set[i] = 0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every operation, faults and their recovery
        write_reg(CFG_LOCALS, 17'd8);
        op(M_START);
        op(M_I64C, 64'h7FFF_FFFF_FFFF_FFFF);
        op(M_I64C, 64'h8000_0000_0000_0001);
        op(M_ADD);
        op(M_I32C, 64'hFFFF_FFFF_8000_0000);
        op(M_LTU);
        op(M_EQZ);
        op(M_LTEE, 0, 7);
        op(M_WRAP);
        op(M_LSET, 0, 0);
        op(M_LGET, 0, 7);
        op(M_I64C, 64'hFFFF);
        op(M_I64C, 64'h0123_4567_89AB_CDEF);
        op(M_STORE, 0, 0, 32'hFFFF_FFFF, 2'd3);
        op(M_I64C, 64'hFFF8);
        op(M_I64C, 64'h0123_4567_89AB_CDEF);
        op(M_STORE, 0, 0, 0, 2'd3);
        op(M_I64C, 64'hFFF0);
        op(M_LOAD, 0, 0, 8, 2'd3);
        op(M_MSIZE);
        op(M_NE);
        op(M_I64C, 64'd5);
        op(M_EQ);
        op(M_AND);
        op(M_BLOCK, 0, 0, 0, 0, 16'h0100);
        op(M_LOOP, 0, 0, 0, 0, 16'h0200);
        op(M_I32C, 0);
        op(M_IF, 0, 0, 0, 0, 16'h0300, 16'h0280);
        op(M_ELSE);
        op(M_END);
        op(M_I32C, 1);
        op(M_BRIF, 0, 0);
        op(M_BR, 0, 1);
        op(M_END);
        op(M_END);
        op(M_DROP);
        op(M_END);
        op(M_LGET, 0, 8);
        op(M_I64C, 1);
        op(t_mode'(MODE_BAD));
        op(M_START);
        op(M_MSIZE, 0, 1);

        run_phase(150, 17, 75, 7'd64, 17'd65536);
        run_phase(150, 75, 17, 7'd127, 17'd131071);
        run_phase(70, 0, 0, 7'd0, 17'd0);
        run_phase(100, 0, 0, 7'd5, 17'd300);
        drain();

        if (mismatches == 0 && result_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/wsme_pkg.sv
design/wsme_ctrl.sv
design/wsme_dp.sv
design/wasm_stack_machine_executor.sv
test/tb.sv
